@@ sv/sbss_pkg.sv @@
`default_nettype none

package sbss_pkg;

    localparam int MAX_DIAMETER_DEF = 256;

    localparam int SAMPLE_W   = 16;
    localparam int FRAC_W     = 16;
    localparam int DIAM_CFG_W = 9;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;

    // register map
    localparam logic [CFG_IDX_W-1:0] REG_STAMP_DIAMETER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_X_FRACTION     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_Y_FRACTION     = 2'd2;

    // one blend request: current sample, its gated neighbors, the fractions and the last flag
    typedef struct packed {
        logic [SAMPLE_W-1:0] cur;
        logic [SAMPLE_W-1:0] left;
        logic [SAMPLE_W-1:0] up;
        logic [SAMPLE_W-1:0] upleft;
        logic [FRAC_W-1:0]   fx;
        logic [FRAC_W-1:0]   fy;
        logic                last;
    } t_blend_req;

endpackage

`default_nettype wire

@@ sv/sbss_blend.sv @@
`default_nettype none

module sbss_blend (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire sbss_pkg::t_blend_req i_req,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic [15:0]             o_shifted_sample,
    output logic                    o_stamp_end
);
    import sbss_pkg::*;

    localparam int W_W   = 2 * FRAC_W + 1;   // weights reach 2^32
    localparam int P_W   = SAMPLE_W + W_W;
    localparam int S_W   = P_W + 1;
    localparam int SHIFT = 2 * FRAC_W;
    localparam logic [FRAC_W:0] FRAC_ONE = {1'b1, {FRAC_W{1'b0}}};

    // per-stage valid and ready
    logic r_v1, r_v2, r_v3, r_v4;
    logic rdy1, rdy2, rdy3, rdy4;

    // stage 1: request
    t_blend_req r_req;

    // stage 2: weights
    logic [SAMPLE_W-1:0] r_s2_cur, r_s2_left, r_s2_up, r_s2_upleft;
    logic [W_W-1:0]      r_w_c, r_w_l, r_w_u, r_w_ul;
    logic                r_s2_last;

    // stage 3: products
    logic [P_W-1:0] r_p_c, r_p_l, r_p_u, r_p_ul;
    logic           r_s3_last;

    // stage 4: output
    logic [SAMPLE_W-1:0] r_out;
    logic                r_out_last;

    logic [FRAC_W:0]  ix, iy;
    logic [W_W-1:0]   n_w_c, n_w_l, n_w_u, n_w_ul;
    logic [S_W-1:0]   sum;

    assign rdy4    = !r_v4 || !i_stall;
    assign rdy3    = !r_v3 || rdy4;
    assign rdy2    = !r_v2 || rdy3;
    assign rdy1    = !r_v1 || rdy2;
    assign o_stall = !rdy1;

    assign ix = FRAC_ONE - {1'b0, r_req.fx};
    assign iy = FRAC_ONE - {1'b0, r_req.fy};

    assign n_w_ul = W_W'(r_req.fx) * W_W'(r_req.fy);
    assign n_w_u  = W_W'(ix)       * W_W'(r_req.fy);
    assign n_w_l  = W_W'(r_req.fx) * W_W'(iy);
    assign n_w_c  = W_W'(ix)       * W_W'(iy);

    assign sum = S_W'(r_p_c) + S_W'(r_p_l) + S_W'(r_p_u) + S_W'(r_p_ul);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_valid;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
            if (rdy4) r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r_req <= i_req;
        end
        if (rdy2) begin
            r_s2_cur    <= r_req.cur;
            r_s2_left   <= r_req.left;
            r_s2_up     <= r_req.up;
            r_s2_upleft <= r_req.upleft;
            r_w_c       <= n_w_c;
            r_w_l       <= n_w_l;
            r_w_u       <= n_w_u;
            r_w_ul      <= n_w_ul;
            r_s2_last   <= r_req.last;
        end
        if (rdy3) begin
            r_p_c     <= P_W'(r_s2_cur)    * P_W'(r_w_c);
            r_p_l     <= P_W'(r_s2_left)   * P_W'(r_w_l);
            r_p_u     <= P_W'(r_s2_up)     * P_W'(r_w_u);
            r_p_ul    <= P_W'(r_s2_upleft) * P_W'(r_w_ul);
            r_s3_last <= r_s2_last;
        end
        if (rdy4) begin
            // truncate: drop the 32 fraction bits
            r_out      <= sum[SHIFT +: SAMPLE_W];
            r_out_last <= r_s3_last;
        end
    end

    assign o_valid          = r_v4;
    assign o_shifted_sample = r_out;
    assign o_stamp_end      = r_out_last;

    // input only backs up when every stage is full and the sink holds off
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_v1 && r_v2 && r_v3 && r_v4 && i_stall))
        else $error("blend pipe stalls with a free stage");

    // a held result stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=>
        (o_valid && $stable(o_shifted_sample) && $stable(o_stamp_end)))
        else $error("stalled result changed");

    // weights sum to 2^32, so nothing is lost above the kept bits
    a_sum_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 |-> (sum[S_W-1:SHIFT+SAMPLE_W] == '0))
        else $error("blend sum above 16 bits");

endmodule

`default_nettype wire

@@ sv/subpixel_bilinear_stamp_shift.sv @@
// Subpixel bilinear stamp shift, one sample in and one sample out per request.
// A request passes the request, weight, product and sum registers in that
// order before o_valid rises with its result. Throughput: one request per
// cycle while o_stall is low; the line buffer does one write and one read
// per request, the read one column ahead. Reset (sync, active low):
// diameter 1, fractions 0, stamp at its first sample, pipeline empty.
`default_nettype none

module subpixel_bilinear_stamp_shift #(
    parameter int MAX_DIAMETER = sbss_pkg::MAX_DIAMETER_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // config write port
    input  wire logic                         i_cfg_we,
    input  wire logic [sbss_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [sbss_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // source mask stream
    input  wire logic                         i_valid,
    output logic                              o_stall,
    input  wire logic [15:0]                  i_mask_sample,
    // shifted mask stream
    output logic                              o_valid,
    input  wire logic                         i_stall,
    output logic [15:0]                       o_shifted_sample,
    output logic                              o_stamp_end
);
    import sbss_pkg::*;

    localparam int CW = $clog2(MAX_DIAMETER);
    localparam logic [CW-1:0] DIAM_M1_MAX = CW'(MAX_DIAMETER - 1);

    // ------------------------------------------------------------------
    // Configuration. The diameter is kept as (effective diameter - 1),
    // already clamped to [1, MAX_DIAMETER], so the position counters only
    // need an equality test against it.
    // ------------------------------------------------------------------
    logic [CW-1:0]     r_diam_m1;
    logic [FRAC_W-1:0] r_fx, r_fy;

    logic [DIAM_CFG_W-1:0] cfg_d;
    logic [CW-1:0]         n_diam_m1;
    logic                  diam_wr;

    assign cfg_d   = i_cfg_data[DIAM_CFG_W-1:0];
    assign diam_wr = i_cfg_we && (i_cfg_index == REG_STAMP_DIAMETER);

    always_comb begin
        if (cfg_d == '0) begin
            n_diam_m1 = '0;                       // zero acts as one
        end else if (32'(cfg_d) > MAX_DIAMETER) begin
            n_diam_m1 = DIAM_M1_MAX;
        end else begin
            n_diam_m1 = CW'(cfg_d - DIAM_CFG_W'(1));
        end
    end

    // ------------------------------------------------------------------
    // Raster position and neighbor registers.
    // ------------------------------------------------------------------
    logic [CW-1:0]       r_col, r_row;
    logic [SAMPLE_W-1:0] r_left, r_upleft;
    logic [SAMPLE_W-1:0] r_row_rd;              // line buffer read data

    logic                in_acc;
    logic                col_last, row_last;
    logic [CW-1:0]       n_col, n_row;
    logic [SAMPLE_W-1:0] nb_left, nb_up, nb_upleft;
    t_blend_req          req;

    assign in_acc   = i_valid && !o_stall;
    assign col_last = (r_col == r_diam_m1);
    assign row_last = (r_row == r_diam_m1);
    assign n_col    = col_last ? '0 : r_col + CW'(1);
    assign n_row    = !col_last ? r_row : (row_last ? '0 : r_row + CW'(1));

    // neighbors outside the stamp read as zero
    assign nb_left   = (r_col != '0) ? r_left : '0;
    assign nb_up     = (r_row != '0) ? r_row_rd : '0;
    assign nb_upleft = ((r_row != '0) && (r_col != '0)) ? r_upleft : '0;

    always_comb begin
        req.cur    = i_mask_sample;
        req.left   = nb_left;
        req.up     = nb_up;
        req.upleft = nb_upleft;
        req.fx     = r_fx;
        req.fy     = r_fy;
        req.last   = col_last && row_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_diam_m1 <= '0;
            r_fx      <= '0;
            r_fy      <= '0;
            r_col     <= '0;
            r_row     <= '0;
            r_left    <= '0;
            r_upleft  <= '0;
        end else begin
            if (in_acc) begin
                r_col    <= n_col;
                r_row    <= n_row;
                r_left   <= i_mask_sample;
                r_upleft <= nb_up;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_STAMP_DIAMETER: begin
                        // restart the stamp
                        r_diam_m1 <= n_diam_m1;
                        r_col     <= '0;
                        r_row     <= '0;
                        r_left    <= '0;
                        r_upleft  <= '0;
                    end
                    REG_X_FRACTION: r_fx <= i_cfg_data[FRAC_W-1:0];
                    REG_Y_FRACTION: r_fy <= i_cfg_data[FRAC_W-1:0];
                    default: ;                    // unmapped index: ignored
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Line buffer. Each request writes its column and reads the column of
    // the next request, so the upper neighbor is registered and ready when
    // that request arrives. For diameters of two or more the two addresses
    // differ; a diameter of one never uses the upper neighbor. Rows above
    // the first are always written earlier in the same stamp.
    // ------------------------------------------------------------------
    logic [SAMPLE_W-1:0] line_mem [MAX_DIAMETER];

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            line_mem[r_col] <= i_mask_sample;
            r_row_rd        <= line_mem[n_col];
        end
    end

    // ------------------------------------------------------------------
    // Blend pipeline: weights, products, truncated sum.
    // ------------------------------------------------------------------
    sbss_blend u_blend (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_req            (req),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_shifted_sample (o_shifted_sample),
        .o_stamp_end      (o_stamp_end)
    );

    a_col_in_stamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col <= r_diam_m1)
        else $error("column outside stamp");

    a_row_in_stamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_row <= r_diam_m1)
        else $error("row outside stamp");

    a_col_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !col_last && !diam_wr) |=> (r_col == $past(r_col) + CW'(1)))
        else $error("column did not advance by one");

endmodule

`default_nettype wire
